### hw/rtl/modexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
// No dependencies; used by modexp_mulmod and modular_exponentiation_top.
package modexp_pkg;

    // Operand width in bits
    localparam int WIDTH = 32;
    // Width of the bit counter in the multiplier; it holds WIDTH itself
    localparam int CNT_W = $clog2(WIDTH + 1);

    // Request to the shared modular multiplier
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] m;
    } mm_req_t;

    // Response from the shared modular multiplier
    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] product;
    } mm_rsp_t;

endpackage

### hw/rtl/modular_exponentiation_top.sv
// Modular exponentiation, right-to-left square-and-multiply on one shared bit-serial
// modular multiplier (modexp_mulmod); uses modexp_pkg. A zero modulus gives done in the
// cycle after the start with a zero result and zero_modulus_error; else the base is
// reduced; each exponent bit up to the top set bit gets a multiply if set, then a square.
// A new start is taken only in idle; busy is high until the done cycle. The result is
// shown for one cycle with done; no stall. Asynchronous active-low reset returns to idle.
module modular_exponentiation_top
    import modexp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] base_value,
    input  logic [31:0] exponent,
    input  logic [31:0] modulus,
    output logic        done,
    output logic [31:0] power_result,
    output logic        zero_modulus_error
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_STEP,
        ST_MUL,
        ST_SQR
    } state_t;

    state_t           state_reg, state_next;
    logic [WIDTH-1:0] exp_reg, exp_next;
    logic [WIDTH-1:0] mod_reg, mod_next;
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic             done_reg, done_next;
    logic [31:0]      res_reg, res_next;
    logic             err_reg, err_next;

    mm_req_t          mm_req;
    mm_rsp_t          mm_rsp;

    modexp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    // Sequencer: reduce base, then per exponent bit multiply if the bit is set, and square
    always_comb
    begin
        state_next = state_reg;
        exp_next   = exp_reg;
        mod_next   = mod_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        err_next   = err_reg;
        mm_req     = '{start: 1'b0, a: acc_reg, b: base_reg, m: mod_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    exp_next = exponent[WIDTH-1:0];
                    mod_next = modulus[WIDTH-1:0];
                    acc_next = WIDTH'(1);
                    if (modulus[WIDTH-1:0] == '0)
                    begin
                        done_next = 1'b1;
                        res_next  = '0;
                        err_next  = 1'b1;
                    end
                    else
                    begin
                        // base mod m computed as 1 * base mod m
                        mm_req     = '{start: 1'b1, a: WIDTH'(1),
                                       b: base_value[WIDTH-1:0],
                                       m: modulus[WIDTH-1:0]};
                        state_next = ST_RED;
                    end
                end
            end
            ST_RED:
            begin
                if (mm_rsp.done)
                begin
                    base_next  = mm_rsp.product;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (exp_reg == '0)
                begin
                    done_next  = 1'b1;
                    res_next   = 32'(acc_reg);
                    err_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (exp_reg[0])
                begin
                    mm_req     = '{start: 1'b1, a: acc_reg, b: base_reg, m: mod_reg};
                    state_next = ST_MUL;
                end
                else
                begin
                    mm_req     = '{start: 1'b1, a: base_reg, b: base_reg, m: mod_reg};
                    state_next = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (mm_rsp.done)
                begin
                    acc_next   = mm_rsp.product;
                    mm_req     = '{start: 1'b1, a: base_reg, b: base_reg, m: mod_reg};
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mm_rsp.done)
                begin
                    base_next  = mm_rsp.product;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
    end

    assign busy               = (state_reg != ST_IDLE);
    assign done               = done_reg;
    assign power_result       = res_reg;
    assign zero_modulus_error = err_reg;

endmodule

### hw/rtl/modexp_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle, MSB first.
// Depends on modexp_pkg (WIDTH, CNT_W, mm_req_t, mm_rsp_t).
module modexp_mulmod
    import modexp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mm_req_t req,
    output mm_rsp_t rsp
);

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   sum_red;
    logic [WIDTH-1:0] acc_next;

    // One Horner step: acc = 2*acc mod m, then + a mod m if the bit is set
    always_comb
    begin
        dbl     = {1'b0, acc_reg} + {1'b0, acc_reg};
        dbl_red = (dbl >= {1'b0, m_reg}) ? (dbl - {1'b0, m_reg}) : dbl;
        sum     = dbl_red + {1'b0, a_reg};
        sum_red = (sum >= {1'b0, m_reg}) ? (sum - {1'b0, m_reg}) : sum;
        if (b_reg[WIDTH-1])
        begin
            acc_next = sum_red[WIDTH-1:0];
        end
        else
        begin
            acc_next = dbl_red[WIDTH-1:0];
        end
    end

    // Control: counter, run flag and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(WIDTH);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            m_reg   <= req.m;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule
